>>> sv/anashift_pkg.sv
// shared constants and types of the anaglyph shift stream unit
package anashift_pkg;

  localparam int PIX_W       = 8;
  localparam int SHIFT_W     = 5;
  localparam int SHIFT_MAX   = (1 << SHIFT_W) - 1;
  localparam int SHIFT_RESET = 5;
  localparam int MAX_SHIFT_DEF = 31;
  localparam int COL_W       = 6;
  localparam int CNT_W       = 6;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'((1 << COL_W) - 1);

  typedef struct packed {
    logic step;
    logic ins;
    logic clr;
  } ring_ctl_t;

endpackage

>>> sv/anaglyph_shift_stream_unit.sv
// top level: red/cyan anaglyph from a shifted pixel stream
// Pixels stream in raster order; a pixel that is not the last of its row gives at most
// one output pixel, so a row runs at one pixel per cycle while the output is not stalled.
// The last pixel of a row stalls the input while it flushes its results (up to shift + 1,
// at most 32), since the flush reads the red history one entry a cycle (while the output
// is not stalled) as the cell ring rotates past its head. The history is a ring of
// 2 * min(MAX_SHIFT, 31) + 1 cells; after a shift write in the middle of a row the ring
// rotates back into line before the next pixel is taken. Output pixel x appears once
// input column x + shift has arrived; short rows come out whole at their end.
module anaglyph_shift_stream_unit #(
  parameter int MAX_SHIFT = anashift_pkg::MAX_SHIFT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [anashift_pkg::SHIFT_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [anashift_pkg::PIX_W-1:0]      pixel_red_i,
  input  logic [anashift_pkg::PIX_W-1:0]      pixel_green_i,
  input  logic [anashift_pkg::PIX_W-1:0]      pixel_blue_i,
  input  logic                                row_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [anashift_pkg::PIX_W-1:0]      out_red_o,
  output logic [anashift_pkg::PIX_W-1:0]      out_green_o,
  output logic [anashift_pkg::PIX_W-1:0]      out_blue_o,
  output logic                                out_row_end_o,
  output logic                                burst_end_o
);

  localparam int MAX_EFF = (MAX_SHIFT < anashift_pkg::SHIFT_MAX) ? MAX_SHIFT
                                                                 : anashift_pkg::SHIFT_MAX;
  localparam int RING    = 2 * MAX_EFF + 1;
  localparam int P_W     = $clog2(RING);
  localparam int RST_S   = (anashift_pkg::SHIFT_RESET < MAX_EFF) ? anashift_pkg::SHIFT_RESET
                                                                 : MAX_EFF;
  localparam logic [P_W-1:0] P_RESET = P_W'(2 * RST_S);
  localparam logic [P_W-1:0] P_LAST  = P_W'(RING - 1);

  localparam int SW = anashift_pkg::SHIFT_W;
  localparam int CW = anashift_pkg::COL_W;
  localparam int NW = anashift_pkg::CNT_W;
  localparam int PW = anashift_pkg::PIX_W;

  logic [SW-1:0]  eye_shift_q;
  logic [CW-1:0]  col_q;
  logic [PW-1:0]  row_first_q;
  logic [P_W-1:0] p_q;
  logic           busy_q;
  logic [NW-1:0]  rem_q;
  logic           rot_q;
  logic           force_q;
  logic           row_q;
  logic [PW-1:0]  green_q;
  logic [PW-1:0]  blue_q;
  logic           out_valid_q;
  logic [PW-1:0]  out_red_q;
  logic [PW-1:0]  out_green_q;
  logic [PW-1:0]  out_blue_q;
  logic           out_row_end_q;
  logic           burst_end_q;

  logic [SW-1:0]  s_eff;
  logic [P_W-1:0] target;
  logic [P_W-1:0] p_dec;
  logic           aligned;
  logic           emit;
  logic           final_emit;
  logic           accept;
  logic           ring_rot;
  logic           ge;
  logic [NW-1:0]  n_flush;
  logic [NW-1:0]  n_total;
  logic [PW-1:0]  head_red;
  logic           head_flag;
  logic [PW-1:0]  emit_red;

  anashift_pkg::ring_ctl_t ring_ctl;

  assign s_eff   = (eye_shift_q > SW'(MAX_EFF)) ? SW'(MAX_EFF) : eye_shift_q;
  assign target  = P_W'({s_eff, 1'b0});
  assign p_dec   = (p_q == '0) ? P_LAST : p_q - 1'b1;
  assign aligned = (p_q == target);

  assign emit       = busy_q && (!out_valid_q || !out_stall_i);
  assign final_emit = emit && (rem_q == NW'(1));

  assign in_stall_o = !(aligned && (!busy_q || (final_emit && !row_q)));
  assign accept     = in_valid_i && !in_stall_o;

  assign ring_rot = (emit && (rem_q != NW'(1)) && rot_q) || (!busy_q && !aligned);

  assign ring_ctl.step = accept || ring_rot;
  assign ring_ctl.ins  = accept;
  assign ring_ctl.clr  = final_emit && row_q;

  // result count of the pixel being taken
  assign ge      = (col_q >= CW'(s_eff));
  assign n_flush = !row_end_i ? '0 : (ge ? NW'(s_eff) : NW'(col_q + 1'b1));
  assign n_total = n_flush + NW'(ge);

  assign emit_red = (force_q || !head_flag) ? row_first_q : head_red;

  anashift_ring #(
    .DEPTH (RING),
    .P_W   (P_W)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ring_ctl),
    .ins_pos_i   (p_q),
    .new_red_i   (pixel_red_i),
    .head_red_o  (head_red),
    .head_flag_o (head_flag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_shift_q <= SW'(anashift_pkg::SHIFT_RESET);
      col_q       <= '0;
      row_first_q <= '0;
      p_q         <= P_RESET;
      busy_q      <= 1'b0;
      rem_q       <= '0;
      rot_q       <= 1'b0;
      force_q     <= 1'b0;
      row_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        eye_shift_q <= cfg_wdata_i;
      end
      if (ring_rot) begin
        p_q <= p_dec;
      end else if (final_emit && row_q) begin
        p_q <= target;
      end
      if (accept) begin
        busy_q  <= (n_total != '0);
        rem_q   <= n_total;
        rot_q   <= ge;
        force_q <= !ge;
        row_q   <= row_end_i;
        if (col_q == '0) begin
          row_first_q <= pixel_red_i;
        end
        if (row_end_i) begin
          col_q <= '0;
        end else if (col_q != anashift_pkg::COL_MAX) begin
          col_q <= col_q + 1'b1;
        end
      end else if (emit) begin
        rem_q <= rem_q - 1'b1;
        if (rem_q == NW'(1)) begin
          busy_q <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      green_q <= pixel_green_i;
      blue_q  <= pixel_blue_i;
    end
    if (emit) begin
      out_red_q     <= emit_red;
      out_green_q   <= green_q;
      out_blue_q    <= blue_q;
      out_row_end_q <= row_q && (rem_q == NW'(1));
      burst_end_q   <= (rem_q == NW'(1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_red_o     = out_red_q;
  assign out_green_o   = out_green_q;
  assign out_blue_o    = out_blue_q;
  assign out_row_end_o = out_row_end_q;
  assign burst_end_o   = burst_end_q;

endmodule

>>> sv/anashift_cell.sv
// one cell of the red history ring: one red value and its current-row flag
module anashift_cell #(
  parameter int IDX = 0,
  parameter int P_W = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  anashift_pkg::ring_ctl_t       ctl_i,
  input  logic [P_W-1:0]                ins_pos_i,
  input  logic [anashift_pkg::PIX_W-1:0] new_red_i,
  input  logic [anashift_pkg::PIX_W-1:0] nbr_red_i,
  input  logic                          nbr_flag_i,
  output logic [anashift_pkg::PIX_W-1:0] red_o,
  output logic                          flag_o
);

  logic [anashift_pkg::PIX_W-1:0] red_q, red_d;
  logic                           flag_q, flag_d;
  logic                           sel_ins;

  assign sel_ins = ctl_i.ins && (ins_pos_i == P_W'(IDX));

  always_comb begin
    red_d  = red_q;
    flag_d = flag_q;
    if (ctl_i.step) begin
      red_d  = sel_ins ? new_red_i : nbr_red_i;
      flag_d = sel_ins ? 1'b1 : nbr_flag_i;
    end
    if (ctl_i.clr) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q <= red_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign red_o  = red_q;
  assign flag_o = flag_q;

endmodule

>>> sv/anashift_ring.sv
// ring of history cells, each handing its value to the next lower cell
module anashift_ring #(
  parameter int DEPTH = 63,
  parameter int P_W   = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  anashift_pkg::ring_ctl_t       ctl_i,
  input  logic [P_W-1:0]                ins_pos_i,
  input  logic [anashift_pkg::PIX_W-1:0] new_red_i,
  output logic [anashift_pkg::PIX_W-1:0] head_red_o,
  output logic                          head_flag_o
);

  logic [anashift_pkg::PIX_W-1:0] red_w  [DEPTH];
  logic                           flag_w [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam int NBR = (k == DEPTH - 1) ? 0 : k + 1;
    anashift_cell #(
      .IDX (k),
      .P_W (P_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_i),
      .ins_pos_i  (ins_pos_i),
      .new_red_i  (new_red_i),
      .nbr_red_i  (red_w[NBR]),
      .nbr_flag_i (flag_w[NBR]),
      .red_o      (red_w[k]),
      .flag_o     (flag_w[k])
    );
  end

  assign head_red_o  = red_w[0];
  assign head_flag_o = flag_w[0];

endmodule

>>> sv/anashift_chk.sv
// port checker for the anaglyph shift stream unit and its bind
module anashift_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           row_end_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [anashift_pkg::PIX_W-1:0] out_red_o,
  input logic [anashift_pkg::PIX_W-1:0] out_green_o,
  input logic [anashift_pkg::PIX_W-1:0] out_blue_o,
  input logic                           out_row_end_o,
  input logic                           burst_end_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  // stalled output keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // stalled output keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_red_o) && $stable(out_green_o) &&
      $stable(out_blue_o) && $stable(out_row_end_o) && $stable(burst_end_o))
    else $error("output payload changed while stalled");

  // the last pixel of a row always closes its burst
  a_row_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_row_end_o |-> burst_end_o)
    else $error("row end without burst end");

  // a row end transfer always starts a flush, so the input stalls next cycle
  a_flush_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && row_end_i |=> in_stall_o)
    else $error("input taken right after a row end");

endmodule

bind anaglyph_shift_stream_unit anashift_chk u_anashift_chk (.*);
